// ----- hdl/drive_command_smoother_top_macros.svh -----
// Assertion macros shared by the drive command smoother modules.
// Each macro expects signals clk and rst in the scope where it is used.
`ifndef DRIVE_COMMAND_SMOOTHER_TOP_MACROS_SVH
`define DRIVE_COMMAND_SMOOTHER_TOP_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define DCS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("drive command smoother: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define DCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drive command smoother: implication violated");

// Consequent holds in the cycle after the antecedent.
`define DCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drive command smoother: next-cycle implication violated");

`endif

// ----- hdl/dcs_pkg.sv -----
// Shared constants, types and register codes of the drive command smoother.
// No dependencies; the divider, controller, datapath and top level import this package.
package dcs_pkg;

  localparam int WINDOW_MAX  = 16;
  localparam int SAMPLE_BITS = 16;

  localparam int SLOT_W  = $clog2(WINDOW_MAX);
  localparam int CNT_W   = $clog2(WINDOW_MAX + 2);
  localparam int TOTAL_W = SAMPLE_BITS + $clog2(WINDOW_MAX);

  localparam int MODE_W     = 3;
  localparam int RATE_W     = 15;
  localparam int DT_W       = 16;
  localparam int WLEN_W     = 5;
  localparam int THRESH_W   = 15;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Mean divider: quotient bits resolved per cycle and iterations per divide.
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_ITERS      = (TOTAL_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int DIV_QW         = DIV_ITERS * DIV_RADIX_BITS;
  localparam int DIV_ITER_W     = $clog2(DIV_ITERS + 1);

  // Smoothing field of the mode register, bits 1:0.
  localparam logic [1:0] SMOOTH_NONE = 2'd0;
  localparam logic [1:0] SMOOTH_SLEW = 2'd1;
  localparam logic [1:0] SMOOTH_AVG  = 2'd2;
  localparam int         MODE_SCALE_BIT = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE           = 3'd0,
    CFG_SPEED_RATE     = 3'd1,
    CFG_STEER_RATE     = 3'd2,
    CFG_WINDOW_LEN     = 3'd3,
    CFG_THRESHOLD      = 3'd4,
    CFG_STRAIGHT_GAIN  = 3'd5,
    CFG_CORNER_GAIN    = 3'd6,
    CFG_STEER_GAIN     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [RATE_W-1:0]   speed_rate;
    logic [RATE_W-1:0]   steer_rate;
    logic [WLEN_W-1:0]   window_len;
    logic [THRESH_W-1:0] straight_threshold;
    logic [GAIN_W-1:0]   straight_speed_gain;
    logic [GAIN_W-1:0]   corner_speed_gain;
    logic [GAIN_W-1:0]   steer_gain;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted request
    logic step;    // form slew steps, read the oldest history entry
    logic filter;  // apply the smoothing mode, start the mean divide
    logic mean;    // take the divider quotients
    logic scale;   // form the gain products
    logic emit;    // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic avg_sel;   // this request runs through the moving average
    logic div_done;  // both mean dividers idle
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

// ----- hdl/dcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module dcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/dcs_div.sv -----
// Multi-cycle signed divider for the moving mean, truncating toward zero.
// Depends on dcs_pkg; resolves DIV_RADIX_BITS quotient bits per cycle.
module dcs_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [dcs_pkg::TOTAL_W-1:0] dividend,
  input  logic        [dcs_pkg::CNT_W-1:0]   divisor,
  output logic                               busy,
  output logic signed [dcs_pkg::TOTAL_W-1:0] quotient
);
  import dcs_pkg::*;

  logic                  neg;
  logic [CNT_W-1:0]      dvs;
  logic [CNT_W:0]        rem;
  logic [CNT_W:0]        rem_next;
  logic [DIV_QW-1:0]     quo;
  logic [DIV_QW-1:0]     quo_next;
  logic [DIV_ITER_W-1:0] iter;
  logic [TOTAL_W-1:0]    mag;
  logic [DIV_QW-1:0]     signed_quo;

  assign mag = dividend[TOTAL_W-1] ? TOTAL_W'(-dividend) : TOTAL_W'(dividend);

  // Restoring steps; remainder stays below the divisor between steps.
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      rem_next = {rem_next[CNT_W-1:0], quo_next[DIV_QW-1]};
      quo_next = {quo_next[DIV_QW-2:0], 1'b0};
      if (rem_next >= {1'b0, dvs}) begin
        rem_next    = rem_next - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= '0;
    end else if (busy) begin
      iter <= iter + 1'b1;
      if (iter == DIV_ITER_W'(DIV_ITERS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[TOTAL_W-1];
      dvs <= divisor;
      rem <= '0;
      quo <= DIV_QW'(mag);
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign signed_quo = neg ? (~quo + 1'b1) : quo;
  assign quotient   = signed'(signed_quo[TOTAL_W-1:0]);

endmodule

// ----- hdl/dcs_ctrl.sv -----
// Sequencing state machine of the drive command smoother.
// Depends on dcs_pkg (command and status structs) and the assertion macros.
`include "drive_command_smoother_top_macros.svh"
module dcs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dcs_pkg::sts_t sts,
  output dcs_pkg::cmd_t cmd
);
  import dcs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_STEP  = 6'b000010,
    S_FILT  = 6'b000100,
    S_DIV   = 6'b001000,
    S_SCALE = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = S_FILT;
      end
      S_FILT: begin
        cmd.filter = 1'b1;
        state_next = sts.avg_sel ? S_DIV : S_SCALE;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.mean   = 1'b1;
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  `DCS_ASSERT_ALWAYS(a_state_onehot, $onehot(state))
  `DCS_ASSERT_NEXT(a_div_wait, state == S_DIV && !sts.div_done, state == S_DIV)
  `DCS_ASSERT_NEXT(a_emit_idle, cmd.emit, in_ready)

endmodule

// ----- hdl/dcs_dp.sv -----
// Datapath of the drive command smoother: slew limiter, moving average with
// history RAM and mean dividers, gain stage and output register.
// Depends on dcs_pkg, dcs_ram, dcs_div and the assertion macros.
`include "drive_command_smoother_top_macros.svh"
module dcs_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dcs_pkg::cfg_t                          cfg,
  input  dcs_pkg::cmd_t                          cmd,
  output dcs_pkg::sts_t                          sts,
  input  logic signed [dcs_pkg::SAMPLE_BITS-1:0] raw_speed,
  input  logic signed [dcs_pkg::SAMPLE_BITS-1:0] raw_steer,
  input  logic        [dcs_pkg::DT_W-1:0]        dt_ticks,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [dcs_pkg::SAMPLE_BITS-1:0] speed_out,
  output logic signed [dcs_pkg::SAMPLE_BITS-1:0] steer_out
);
  import dcs_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int PROD_W = SB + GAIN_W + 1;
  localparam int RQ_W   = PROD_W - GAIN_FRAC;
  localparam int STEP_W = RATE_W + DT_W;

  function automatic logic signed [SB-1:0] slew_limit(
    input logic signed [SB-1:0] prev,
    input logic signed [SB-1:0] target,
    input logic [RATE_W-1:0]    step
  );
    logic signed [SB+1:0] prev_x;
    logic signed [SB+1:0] diff;
    logic signed [SB+1:0] stp;
    logic signed [SB+1:0] res;
    prev_x = {{2{prev[SB-1]}}, prev};
    diff   = {{2{target[SB-1]}}, target} - prev_x;
    stp    = signed'({{(SB + 2 - RATE_W){1'b0}}, step});
    if (diff > stp) begin
      res = prev_x + stp;
    end else if (diff < -stp) begin
      res = prev_x - stp;
    end else begin
      res = {{2{target[SB-1]}}, target};
    end
    return res[SB-1:0];
  endfunction

  function automatic logic signed [TOTAL_W-1:0] widen(input logic signed [SB-1:0] v);
    return {{(TOTAL_W - SB){v[SB-1]}}, v};
  endfunction

  // Round to nearest, ties away from zero, then saturate to the sample range.
  function automatic logic signed [SB-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] rnd;
    logic [RQ_W-1:0]   q;
    logic [RQ_W-1:0]   negq;
    mag  = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    rnd  = mag + (PROD_W'(1) << (GAIN_FRAC - 1));
    q    = rnd[PROD_W-1:GAIN_FRAC];
    negq = ~q + 1'b1;
    if (!p[PROD_W-1]) begin
      return (q > RQ_W'((1 << (SB - 1)) - 1)) ? {1'b0, {(SB - 1){1'b1}}} : q[SB-1:0];
    end
    return (q > RQ_W'(1 << (SB - 1))) ? {1'b1, {(SB - 1){1'b0}}} : negq[SB-1:0];
  endfunction

  // Captured request
  logic signed [SB-1:0] raw_speed_q;
  logic signed [SB-1:0] raw_steer_q;
  logic [DT_W-1:0]      dt_q;

  // Smoother state
  logic                      first_pending;
  logic signed [SB-1:0]      last_speed;
  logic signed [SB-1:0]      last_steer;
  logic [CNT_W-1:0]          fill_count;
  logic [SLOT_W-1:0]         write_slot;
  logic signed [TOTAL_W-1:0] speed_total;
  logic signed [TOTAL_W-1:0] steer_total;

  // Working registers
  logic [RATE_W-1:0]        speed_step;
  logic [RATE_W-1:0]        steer_step;
  logic signed [SB-1:0]     filt_speed;
  logic signed [SB-1:0]     filt_steer;
  logic signed [PROD_W-1:0] speed_prod;
  logic signed [PROD_W-1:0] steer_prod;

  logic [1:0]  smooth;
  logic        scale_en;
  logic        slew_sel;
  logic        avg_sel;
  logic [STEP_W-1:0] speed_rate_prod;
  logic [STEP_W-1:0] steer_rate_prod;

  logic [CNT_W-1:0]  w_eff;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  cnt_eff;
  logic              drop;
  logic [CNT_W:0]    ws_x;
  logic [CNT_W:0]    fl_x;
  logic [CNT_W:0]    old_x;
  logic [SLOT_W-1:0] old_slot;
  logic [SLOT_W-1:0] next_slot;

  logic [2*SB-1:0]           hist_rdata;
  logic signed [SB-1:0]      old_speed;
  logic signed [SB-1:0]      old_steer;
  logic signed [TOTAL_W-1:0] speed_total_next;
  logic signed [TOTAL_W-1:0] steer_total_next;
  logic                      hist_we;
  logic                      div_start;
  logic                      speed_div_busy;
  logic                      steer_div_busy;
  logic signed [TOTAL_W-1:0] speed_mean;
  logic signed [TOTAL_W-1:0] steer_mean;

  logic [SB:0]             steer_abs;
  logic [GAIN_W-1:0]       speed_gain;
  logic signed [GAIN_W:0]  speed_gain_s;
  logic signed [GAIN_W:0]  steer_gain_s;

  assign smooth   = cfg.mode[1:0];
  assign scale_en = cfg.mode[MODE_SCALE_BIT];
  assign slew_sel = !first_pending && (smooth == SMOOTH_SLEW);
  assign avg_sel  = !first_pending && (smooth == SMOOTH_AVG);

  assign speed_rate_prod = STEP_W'(cfg.speed_rate) * STEP_W'(dt_q);
  assign steer_rate_prod = STEP_W'(cfg.steer_rate) * STEP_W'(dt_q);

  // Window bookkeeping: clamp the length, decide whether the oldest drops.
  always_comb begin
    if (cfg.window_len == '0) begin
      w_eff = CNT_W'(1);
    end else if (int'(cfg.window_len) > WINDOW_MAX) begin
      w_eff = CNT_W'(WINDOW_MAX);
    end else begin
      w_eff = CNT_W'(cfg.window_len);
    end
  end

  assign cnt_inc = fill_count + 1'b1;
  assign drop    = cnt_inc > w_eff;
  assign cnt_eff = drop ? fill_count : cnt_inc;

  assign ws_x     = (CNT_W + 1)'(write_slot);
  assign fl_x     = (CNT_W + 1)'(fill_count);
  assign old_x    = (ws_x >= fl_x) ? (ws_x - fl_x) : (ws_x + (CNT_W + 1)'(WINDOW_MAX) - fl_x);
  assign old_slot = old_x[SLOT_W-1:0];
  assign next_slot = (write_slot == SLOT_W'(WINDOW_MAX - 1)) ? '0 : (write_slot + 1'b1);

  assign old_speed = drop ? signed'(hist_rdata[2*SB-1:SB]) : '0;
  assign old_steer = drop ? signed'(hist_rdata[SB-1:0]) : '0;
  assign speed_total_next = speed_total - widen(old_speed) + widen(raw_speed_q);
  assign steer_total_next = steer_total - widen(old_steer) + widen(raw_steer_q);

  assign hist_we   = cmd.filter && avg_sel;
  assign div_start = cmd.filter && avg_sel;

  dcs_ram #(
    .WIDTH (2 * SB),
    .DEPTH (WINDOW_MAX)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (write_slot),
    .wdata ({raw_speed_q, raw_steer_q}),
    .re    (cmd.step),
    .raddr (old_slot),
    .rdata (hist_rdata)
  );

  dcs_div u_speed_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (speed_total_next),
    .divisor  (cnt_eff),
    .busy     (speed_div_busy),
    .quotient (speed_mean)
  );

  dcs_div u_steer_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (steer_total_next),
    .divisor  (cnt_eff),
    .busy     (steer_div_busy),
    .quotient (steer_mean)
  );

  // Gain choice follows the filtered steering magnitude.
  assign steer_abs    = filt_steer[SB-1] ? (SB + 1)'(-filt_steer) : (SB + 1)'(filt_steer);
  assign speed_gain   = (steer_abs < (SB + 1)'(cfg.straight_threshold)) ?
                        cfg.straight_speed_gain : cfg.corner_speed_gain;
  assign speed_gain_s = signed'({1'b0, speed_gain});
  assign steer_gain_s = signed'({1'b0, cfg.steer_gain});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_speed_q <= raw_speed;
      raw_steer_q <= raw_steer;
      dt_q        <= dt_ticks;
    end
    if (cmd.step) begin
      speed_step <= speed_rate_prod[STEP_W-1:DT_W];
      steer_step <= steer_rate_prod[STEP_W-1:DT_W];
    end
    if (cmd.filter) begin
      if (first_pending) begin
        filt_speed <= raw_speed_q;
        filt_steer <= raw_steer_q;
      end else if (slew_sel) begin
        filt_speed <= slew_limit(last_speed, raw_speed_q, speed_step);
        filt_steer <= slew_limit(last_steer, raw_steer_q, steer_step);
      end else if (!avg_sel) begin
        filt_speed <= raw_speed_q;
        filt_steer <= raw_steer_q;
      end
    end else if (cmd.mean) begin
      filt_speed <= speed_mean[SB-1:0];
      filt_steer <= steer_mean[SB-1:0];
    end
    if (cmd.scale) begin
      speed_prod <= filt_speed * speed_gain_s;
      steer_prod <= filt_steer * steer_gain_s;
    end
    if (cmd.emit) begin
      speed_out <= scale_en ? round_sat(speed_prod) : filt_speed;
      steer_out <= scale_en ? round_sat(steer_prod) : filt_steer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
      last_speed    <= '0;
      last_steer    <= '0;
      fill_count    <= '0;
      write_slot    <= '0;
      speed_total   <= '0;
      steer_total   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.filter) begin
        if (first_pending) begin
          first_pending <= 1'b0;
          last_speed    <= raw_speed_q;
          last_steer    <= raw_steer_q;
        end else if (slew_sel) begin
          last_speed <= slew_limit(last_speed, raw_speed_q, speed_step);
          last_steer <= slew_limit(last_steer, raw_steer_q, steer_step);
        end else if (avg_sel) begin
          speed_total <= speed_total_next;
          steer_total <= steer_total_next;
          fill_count  <= cnt_eff;
          write_slot  <= next_slot;
        end
      end else if (cmd.mean) begin
        last_speed <= speed_mean[SB-1:0];
        last_steer <= steer_mean[SB-1:0];
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.avg_sel  = avg_sel;
  assign sts.div_done = !speed_div_busy && !steer_div_busy;
  assign sts.out_free = !out_valid || out_ready;

  `DCS_ASSERT_ALWAYS(a_fill_bound, fill_count <= CNT_W'(WINDOW_MAX))
  `DCS_ASSERT_NEXT(a_div_starts, cmd.filter && sts.avg_sel, !sts.div_done)
  `DCS_ASSERT_NEXT(a_out_source, !out_valid && !cmd.emit, !out_valid)

endmodule

// ----- hdl/drive_command_smoother_top.sv -----
// Top level of the drive command smoother: configuration registers and the
// controller/datapath pair. Depends on dcs_pkg, dcs_ctrl and dcs_dp.
//
// Smooths a two-channel drive request (speed and steering, signed Q7.8) that
// carries its own time step. Mode bits 1:0 pick pass-through, slew limiting
// (each channel moves by at most rate * dt / 2^16 from its previous output)
// or a moving mean, truncated toward zero, over the last window_len requests
// (window_len clamped to 1..16); mode bit 2 adds a gain stage with rounding
// and saturation. The very first request after reset only seeds the previous
// outputs and is passed through. One request is in flight at a time. In
// average mode a request also waits for the two mean dividers, which resolve
// four quotient bits per cycle. A new request can be taken once the previous
// one has been loaded into the output register, even while that result still
// waits for out_ready. Configuration writes are always accepted (cfg_ready is
// tied high) and should be made only while no request is in progress.
module drive_command_smoother_top (
  input  logic                                   clk,
  input  logic                                   rst,
  // input requests
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [dcs_pkg::SAMPLE_BITS-1:0] raw_speed,
  input  logic signed [dcs_pkg::SAMPLE_BITS-1:0] raw_steer,
  input  logic        [dcs_pkg::DT_W-1:0]        dt_ticks,
  // results
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [dcs_pkg::SAMPLE_BITS-1:0] speed_out,
  output logic signed [dcs_pkg::SAMPLE_BITS-1:0] steer_out,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [dcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [dcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dcs_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Register file never stalls a write.
  assign cfg_ready = 1'b1;

  // Hold the configuration; reset to unity gains, full rates, window of five.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode                <= '0;
      cfg.speed_rate          <= RATE_W'(32767);
      cfg.steer_rate          <= RATE_W'(32767);
      cfg.window_len          <= WLEN_W'(5);
      cfg.straight_threshold  <= THRESH_W'(26);
      cfg.straight_speed_gain <= GAIN_W'(16384);
      cfg.corner_speed_gain   <= GAIN_W'(16384);
      cfg.steer_gain          <= GAIN_W'(16384);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:          cfg.mode                <= cfg_data[MODE_W-1:0];
        CFG_SPEED_RATE:    cfg.speed_rate          <= cfg_data[RATE_W-1:0];
        CFG_STEER_RATE:    cfg.steer_rate          <= cfg_data[RATE_W-1:0];
        CFG_WINDOW_LEN:    cfg.window_len          <= cfg_data[WLEN_W-1:0];
        CFG_THRESHOLD:     cfg.straight_threshold  <= cfg_data[THRESH_W-1:0];
        CFG_STRAIGHT_GAIN: cfg.straight_speed_gain <= cfg_data[GAIN_W-1:0];
        CFG_CORNER_GAIN:   cfg.corner_speed_gain   <= cfg_data[GAIN_W-1:0];
        CFG_STEER_GAIN:    cfg.steer_gain          <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequence each request: capture, step, filter, optional mean divide,
  // gain, then load the output register once it is free.
  dcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dcs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .raw_speed (raw_speed),
    .raw_steer (raw_steer),
    .dt_ticks  (dt_ticks),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .speed_out (speed_out),
    .steer_out (steer_out)
  );

endmodule
